FILE: src/atilt_pkg.sv
// atilt_pkg: constants, arctangent table and pipeline depths for the tilt angle core
// no dependencies; used by atilt_atan2 and accel_tilt_angles_core
package atilt_pkg;

   localparam int ATAN_TABLE_LOG2 = 3;
   localparam int TBL_LG    = (ATAN_TABLE_LOG2 == 4) ? 4 : 3;
   localparam int IDX_W     = TBL_LG + 1;
   localparam int TBL_LAST  = 1 << TBL_LG;
   localparam int FRAC_BITS = 16 - TBL_LG;
   localparam int FRAC_MASK = (1 << FRAC_BITS) - 1;
   localparam int PROD_W    = 16 + FRAC_BITS;

   // reciprocal of the fraction mask for the interpolation divide
   localparam int RECIP_SH  = 40;
   localparam int RECIP_W   = 41 - FRAC_BITS;
   localparam logic [63:0] RECIP_WIDE = (64'd1 << RECIP_SH) / FRAC_MASK;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

   localparam int SQRT_STEPS = 16;
   localparam int DIV_STEPS  = 16;
   // fold + divide steps + five interpolation stages
   localparam int ATAN_LAT   = 1 + DIV_STEPS + 5;
   // input, squares, sum, root steps, rounding
   localparam int FRONT_LAT  = 3 + SQRT_STEPS + 1;
   localparam int PIPE_LAT   = FRONT_LAT + ATAN_LAT;

   typedef logic [15:0] angle_type;

   // arctangent over 0..45 degrees scaled to 0..65535, clamped at the last entry
   function automatic logic [15:0] atan_tab(input logic [IDX_W-1:0] i);
      logic [15:0] v;
      v = 16'd65535;
      if (TBL_LG == 4) begin
         unique case (i)
            0:  v = 16'd0;
            1:  v = 16'd5211;
            2:  v = 16'd10381;
            3:  v = 16'd15473;
            4:  v = 16'd20451;
            5:  v = 16'd25284;
            6:  v = 16'd29949;
            7:  v = 16'd34427;
            8:  v = 16'd38703;
            9:  v = 16'd42771;
            10: v = 16'd46628;
            11: v = 16'd50274;
            12: v = 16'd53714;
            13: v = 16'd56953;
            14: v = 16'd60000;
            15: v = 16'd62864;
            default: v = 16'd65535;
         endcase
      end else begin
         unique case (i)
            0: v = 16'd0;
            1: v = 16'd10397;
            2: v = 16'd20480;
            3: v = 16'd29990;
            4: v = 16'd38753;
            5: v = 16'd46684;
            6: v = 16'd53773;
            7: v = 16'd60062;
            default: v = 16'd65535;
         endcase
      end
      return v;
   endfunction

endpackage

FILE: src/atilt_atan2.sv
// atilt_atan2: pipelined binary-angle atan2 from magnitudes and signs
// depends on atilt_pkg (table, divide and interpolation constants)
module atilt_atan2
   import atilt_pkg::*;
(
   input  logic      clock,
   input  logic      en,
   input  logic [15:0] a_mag,   // first argument magnitude
   input  logic      a_neg,
   input  logic [15:0] b_mag,   // second argument magnitude
   input  logic      b_neg,
   output angle_type angle
);

   typedef struct packed {
      logic zero;
      logic gt;
      logic a_neg;
      logic b_neg;
   } flag_type;

   // divide line: index 0 is the fold register
   logic [15:0] rem_ff [0:DIV_STEPS];
   logic [15:0] rem_in [0:DIV_STEPS];
   logic [15:0] nlo_ff [0:DIV_STEPS];
   logic [15:0] nlo_in [0:DIV_STEPS];
   logic [15:0] quo_ff [0:DIV_STEPS];
   logic [15:0] quo_in [0:DIV_STEPS];
   logic [15:0] den_ff [0:DIV_STEPS];
   logic [15:0] den_in [0:DIV_STEPS];
   flag_type    flg_ff [0:DIV_STEPS];
   flag_type    flg_in [0:DIV_STEPS];

   logic [15:0] small_c, large_c;
   logic [31:0] num_c;
   logic [16:0] shl_c [1:DIV_STEPS];

   // interpolation stages
   logic [15:0]          lo1_ff, lo1_in, dif1_ff, dif1_in;
   logic [FRAC_BITS-1:0] frc1_ff, frc1_in;
   flag_type             f1_ff, f2_ff, f3_ff, f4_ff;
   logic [15:0]          lo2_ff, lo3_ff, lo4_ff;
   logic [PROD_W-1:0]    p2_ff, p2_in, p3_ff;
   logic [15:0]          qe3_ff, qe3_in, qe4_ff;
   logic [PROD_W-1:0]    rr4_ff, rr4_in;
   logic [PROD_W+RECIP_W-1:0] recip_prod;
   logic [PROD_W+15:0]   back_prod;
   logic [IDX_W-1:0]     idx_c;
   logic [15:0]          hi_c;
   logic [15:0]          q5_c, a16_c, a_c;
   logic [13:0]          s14_c;
   logic [14:0]          s15_c;
   angle_type            angle_ff, angle_in;

   always_comb begin
      flg_in[0].zero  = (a_mag == 16'd0) && (b_mag == 16'd0);
      flg_in[0].gt    = b_mag > a_mag;
      flg_in[0].a_neg = a_neg;
      flg_in[0].b_neg = b_neg;
      small_c = flg_in[0].gt ? a_mag : b_mag;
      large_c = flg_in[0].gt ? b_mag : a_mag;
      num_c   = {small_c, 16'd0} - {16'd0, small_c};
      rem_in[0] = num_c[31:16];
      nlo_in[0] = num_c[15:0];
      quo_in[0] = 16'd0;
      den_in[0] = large_c;
      // one quotient bit per stage
      for (int k = 1; k <= DIV_STEPS; k++) begin
         shl_c[k] = {rem_ff[k-1], nlo_ff[k-1][15]};
         if (shl_c[k] >= {1'b0, den_ff[k-1]}) begin
            rem_in[k] = 16'(shl_c[k] - {1'b0, den_ff[k-1]});
            quo_in[k] = {quo_ff[k-1][14:0], 1'b1};
         end else begin
            rem_in[k] = shl_c[k][15:0];
            quo_in[k] = {quo_ff[k-1][14:0], 1'b0};
         end
         nlo_in[k] = {nlo_ff[k-1][14:0], 1'b0};
         den_in[k] = den_ff[k-1];
         flg_in[k] = flg_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            nlo_ff[k] <= nlo_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_in[k];
            flg_ff[k] <= flg_in[k];
         end
      end
   end

   // table lookup, product, reciprocal estimate, remainder, final fold
   always_comb begin
      idx_c   = quo_ff[DIV_STEPS][15:FRAC_BITS];
      lo1_in  = atan_tab(idx_c);
      hi_c    = atan_tab(IDX_W'(idx_c + 1'b1));
      dif1_in = (hi_c >= lo1_in) ? 16'(hi_c - lo1_in) : 16'd0;
      frc1_in = quo_ff[DIV_STEPS][FRAC_BITS-1:0];

      p2_in = PROD_W'(dif1_ff) * PROD_W'(frc1_ff);

      recip_prod = (PROD_W+RECIP_W)'(p2_ff) * (PROD_W+RECIP_W)'(RECIP);
      qe3_in     = recip_prod[RECIP_SH +: 16];

      back_prod = (PROD_W+16)'(qe3_ff) * (PROD_W+16)'(FRAC_MASK);
      rr4_in    = PROD_W'((PROD_W+16)'(p3_ff) - back_prod);

      q5_c  = (rr4_ff >= PROD_W'(FRAC_MASK)) ? 16'(qe4_ff + 16'd1) : qe4_ff;
      a16_c = 16'(lo4_ff + q5_c);
      a_c   = f4_ff.gt ? {1'b0, a16_c[15:1]} : ~{1'b0, a16_c[15:1]};
      s14_c = a_c[15:2];
      s15_c = f4_ff.b_neg ? 15'(15'd32767 - {1'b0, s14_c}) : {1'b0, s14_c};
      if (f4_ff.zero)
         angle_in = '0;
      else if (f4_ff.a_neg)
         angle_in = 16'(-{1'b0, s15_c});
      else
         angle_in = {1'b0, s15_c};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo1_ff   <= lo1_in;
         dif1_ff  <= dif1_in;
         frc1_ff  <= frc1_in;
         f1_ff    <= flg_ff[DIV_STEPS];
         p2_ff    <= p2_in;
         lo2_ff   <= lo1_ff;
         f2_ff    <= f1_ff;
         qe3_ff   <= qe3_in;
         p3_ff    <= p2_ff;
         lo3_ff   <= lo2_ff;
         f3_ff    <= f2_ff;
         qe4_ff   <= qe3_ff;
         rr4_ff   <= rr4_in;
         lo4_ff   <= lo3_ff;
         f4_ff    <= f3_ff;
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

FILE: src/accel_tilt_angles_core.sv
// accel_tilt_angles_core: roll and pitch from one accelerometer sample
// depends on atilt_pkg and atilt_atan2
//
// channel | dir | payload (low bits first)
// req_    | in  | tdata = accel_x, accel_y, accel_z (16 bits signed each)
// rsp_    | out | tdata = roll_angle, pitch_angle (16 bits signed each)
//
// one request per cycle while no stall on rsp_tready holds the pipeline
// a request passes the 16-step root line followed by the 16-step divide line
// reset is synchronous and clears only the valid line
// a stall on rsp_tready freezes the whole pipeline; req_tready drops with it
module accel_tilt_angles_core
   import atilt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // accel_x, accel_y, accel_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // roll_angle, pitch_angle
);

   logic en;
   logic [PIPE_LAT-1:0] vld_ff, vld_in;

   // input and square stages
   logic signed [15:0] x0_ff, y0_ff, z0_ff;
   logic signed [15:0] x1_ff, y1_ff, z1_ff;
   logic signed [31:0] py_c, pz_c;
   logic [30:0]        py1_ff, pz1_ff;

   // root line: index 0 holds the sum y*y + z*z
   logic [31:0]        rem_ff [0:SQRT_STEPS];
   logic [31:0]        rem_in [0:SQRT_STEPS];
   logic [31:0]        res_ff [0:SQRT_STEPS];
   logic [31:0]        res_in [0:SQRT_STEPS];
   logic signed [15:0] xs_ff  [0:SQRT_STEPS];
   logic signed [15:0] ys_ff  [0:SQRT_STEPS];
   logic signed [15:0] zs_ff  [0:SQRT_STEPS];
   logic [31:0]        trial_c [0:SQRT_STEPS-1];
   logic [31:0]        acc_c   [0:SQRT_STEPS-1];

   // rounded and saturated root
   logic [16:0]        rnd_c;
   logic [15:0]        r_ff, r_in;
   logic signed [15:0] xr_ff, yr_ff, zr_ff;

   angle_type roll_c, pitch_c;
   logic [15:0] xmag_c, ymag_c, zmag_c;
   logic        nx_neg_c;

   // pipeline advances whenever the output slot is free or being drained
   assign en         = rsp_tready || !rsp_tvalid;
   assign req_tready = en;
   assign vld_in     = {vld_ff[PIPE_LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign py_c = y0_ff * y0_ff;
   assign pz_c = z0_ff * z0_ff;

   always_comb begin
      rem_in[0] = {1'b0, py1_ff} + {1'b0, pz1_ff};
      res_in[0] = '0;
      // digit-by-digit root, one result bit per stage
      for (int k = 0; k < SQRT_STEPS; k++) begin
         trial_c[k] = res_ff[k] + (32'd1 << (30 - 2 * k));
         if (rem_ff[k] >= trial_c[k]) begin
            rem_in[k+1] = rem_ff[k] - trial_c[k];
            acc_c[k]    = res_ff[k] + (32'd1 << (31 - 2 * k));
         end else begin
            rem_in[k+1] = rem_ff[k];
            acc_c[k]    = res_ff[k];
         end
         res_in[k+1] = acc_c[k] >> 1;
      end
      // round to nearest, then clamp to the positive 16-bit range
      rnd_c = (rem_ff[SQRT_STEPS] > res_ff[SQRT_STEPS]) ?
              17'(res_ff[SQRT_STEPS][16:0] + 17'd1) : res_ff[SQRT_STEPS][16:0];
      r_in  = (rnd_c > 17'd32767) ? 16'd32767 : rnd_c[15:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff  <= req_tdata[15:0];
         y0_ff  <= req_tdata[31:16];
         z0_ff  <= req_tdata[47:32];
         x1_ff  <= x0_ff;
         y1_ff  <= y0_ff;
         z1_ff  <= z0_ff;
         py1_ff <= py_c[30:0];
         pz1_ff <= pz_c[30:0];
         xs_ff[0] <= x1_ff;
         ys_ff[0] <= y1_ff;
         zs_ff[0] <= z1_ff;
         for (int k = 0; k <= SQRT_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            res_ff[k] <= res_in[k];
         end
         for (int k = 1; k <= SQRT_STEPS; k++) begin
            xs_ff[k] <= xs_ff[k-1];
            ys_ff[k] <= ys_ff[k-1];
            zs_ff[k] <= zs_ff[k-1];
         end
         r_ff  <= r_in;
         xr_ff <= xs_ff[SQRT_STEPS];
         yr_ff <= ys_ff[SQRT_STEPS];
         zr_ff <= zs_ff[SQRT_STEPS];
      end
   end

   // magnitudes; -32768 maps to 32768
   assign xmag_c   = xr_ff[15] ? 16'(~xr_ff + 16'sd1) : xr_ff;
   assign ymag_c   = yr_ff[15] ? 16'(~yr_ff + 16'sd1) : yr_ff;
   assign zmag_c   = zr_ff[15] ? 16'(~zr_ff + 16'sd1) : zr_ff;
   // sign of -x, where negating -32768 wraps back to itself
   assign nx_neg_c = (!xr_ff[15] && (xr_ff != 16'sd0)) || (xr_ff == -16'sd32768);

   atilt_atan2 u_roll (
      .clock (clock),
      .en    (en),
      .a_mag (ymag_c),
      .a_neg (yr_ff[15]),
      .b_mag (zmag_c),
      .b_neg (zr_ff[15]),
      .angle (roll_c)
   );

   atilt_atan2 u_pitch (
      .clock (clock),
      .en    (en),
      .a_mag (xmag_c),
      .a_neg (nx_neg_c),
      .b_mag (r_ff),
      .b_neg (1'b0),
      .angle (pitch_c)
   );

   assign rsp_tvalid = vld_ff[PIPE_LAT-1];
   assign rsp_tdata  = {pitch_c, roll_c};

endmodule
